### hw/rtl/ptq_pkg.sv
`default_nettype none

package ptq_pkg;

    // Field widths of the request and result.
    localparam int PRICE_W = 47;
    localparam int TICK_W  = 32;
    localparam int OPC_W   = 2;
    localparam int NEWP_W  = PRICE_W + 1;

    // Opcodes.
    localparam logic [OPC_W-1:0] OP_ROUND = 2'd0;
    localparam logic [OPC_W-1:0] OP_UP    = 2'd1;
    localparam logic [OPC_W-1:0] OP_DOWN  = 2'd2;

    // Input request.
    typedef struct packed {
        logic signed [PRICE_W-1:0] price;
        logic [TICK_W-1:0]         tick;
        logic [OPC_W-1:0]          opcode;
    } ptq_req_t;

    // Result.
    typedef struct packed {
        logic signed [NEWP_W-1:0] new_price;
        logic                     changed;
        logic                     bad_tick;
    } ptq_res_t;

    // Control bits that travel with a request through the pipeline.
    typedef struct packed {
        logic             neg;
        logic             bad;
        logic [OPC_W-1:0] op;
    } ptq_ctl_t;

    // Divider stage contents: magnitude, divisor and partial remainder.
    typedef struct packed {
        logic [PRICE_W-1:0] a;
        logic [TICK_W-1:0]  tick;
        logic [TICK_W-1:0]  rem;
        ptq_ctl_t           ctl;
    } ptq_div_t;

endpackage

`default_nettype wire

### hw/rtl/ptq_div_stage.sv
`default_nettype none

module ptq_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  ptq_pkg::ptq_div_t in_data,
    input  logic              in_bit,
    output logic              out_valid,
    output ptq_pkg::ptq_div_t out_data
);
    import ptq_pkg::*;

    logic [TICK_W:0] trial;
    logic [TICK_W:0] diff;
    ptq_div_t        data_next;
    ptq_div_t        data_reg;
    logic            valid_reg;

    // One restoring step: shift in the next dividend bit and subtract the tick if it fits.
    always_comb begin
        trial     = {in_data.rem, in_bit};
        diff      = trial - {1'b0, in_data.tick};
        data_next = in_data;
        if (trial >= {1'b0, in_data.tick}) begin
            data_next.rem = diff[TICK_W-1:0];
        end else begin
            data_next.rem = trial[TICK_W-1:0];
        end
    end

    // Valid bit of this stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### hw/rtl/ptq_fixup.sv
`default_nettype none

module ptq_fixup (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  ptq_pkg::ptq_div_t in_data,
    output logic              out_valid,
    output ptq_pkg::ptq_res_t out_data
);
    import ptq_pkg::*;

    typedef struct packed {
        logic [PRICE_W-1:0] a;
        logic [TICK_W-1:0]  tick;
        logic [PRICE_W-1:0] base;
        logic               rz;
        logic               up;
        ptq_ctl_t           ctl;
    } fx_a_t;

    typedef struct packed {
        logic [NEWP_W-1:0]  m;
        logic [PRICE_W-1:0] a;
        logic               neg;
        logic               bad;
    } fx_b_t;

    fx_a_t             a_next;
    fx_a_t             a_reg;
    fx_b_t             b_next;
    fx_b_t             b_reg;
    ptq_res_t          c_next;
    ptq_res_t          c_reg;
    logic              a_valid_reg;
    logic              b_valid_reg;
    logic              c_valid_reg;
    logic [NEWP_W-1:0] base_e;
    logic [NEWP_W-1:0] tick_e;
    logic [NEWP_W-1:0] a_e;
    logic [NEWP_W-1:0] neg_m;

    // First stage: the grid point below the magnitude is a minus the remainder.
    always_comb begin
        a_next      = '0;
        a_next.a    = in_data.a;
        a_next.tick = in_data.tick;
        a_next.base = in_data.a - {{(PRICE_W-TICK_W){1'b0}}, in_data.rem};
        a_next.rz   = (in_data.rem == '0);
        a_next.up   = ({in_data.rem, 1'b0} >= {1'b0, in_data.tick});
        a_next.ctl  = in_data.ctl;
    end

    // Second stage: magnitude of the result before the sign is applied.
    always_comb begin
        base_e   = {1'b0, a_reg.base};
        tick_e   = {{(NEWP_W-TICK_W){1'b0}}, a_reg.tick};
        a_e      = {1'b0, a_reg.a};
        b_next   = '0;
        b_next.a = a_reg.a;
        b_next.neg = a_reg.ctl.neg;
        b_next.bad = a_reg.ctl.bad;
        case (a_reg.ctl.op)
            OP_ROUND: begin
                b_next.m = base_e + (a_reg.up ? tick_e : '0);
            end
            OP_UP: begin
                if (a_reg.ctl.neg) begin
                    b_next.m = base_e - (a_reg.rz ? tick_e : '0);
                end else begin
                    b_next.m = base_e + tick_e;
                end
            end
            OP_DOWN: begin
                if (a_reg.ctl.neg) begin
                    b_next.m = base_e + tick_e;
                end else begin
                    b_next.m = base_e - (a_reg.rz ? tick_e : '0);
                end
            end
            default: begin
                b_next.m = a_e;
            end
        endcase
        // A zero tick passes the price through.
        if (a_reg.ctl.bad) begin
            b_next.m = a_e;
        end
    end

    // Third stage: apply the sign and compare against the input magnitude.
    always_comb begin
        neg_m            = '0 - b_reg.m;
        c_next.new_price = b_reg.neg ? neg_m : b_reg.m;
        c_next.changed   = (b_reg.m != {1'b0, b_reg.a});
        c_next.bad_tick  = b_reg.bad;
    end

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            a_reg <= a_next;
        end
        if (en && a_valid_reg) begin
            b_reg <= b_next;
        end
        if (en && b_valid_reg) begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_reg;

endmodule

`default_nettype wire

### hw/rtl/price_tick_quantizer.sv
// Places a signed fixed-point price on the grid of multiples of a tick size: opcode 0 rounds
// to the nearest multiple with halves away from zero, opcode 1 steps to the next multiple
// strictly above, opcode 2 to the next strictly below; a zero tick raises bad_tick and passes
// the price through, and the unused opcode passes it through as well. The block takes one
// request every cycle while s_ready is high and passes each result through one input stage,
// 47 restoring divider stages that each take one step of |price| / tick and keep only the
// remainder, three stages that form and sign the result, and the output register. A
// two-entry output buffer lets the pipeline keep taking requests while a result waits, and
// s_ready drops only once that buffer holds a second result.
`default_nettype none

module price_tick_quantizer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptq_pkg::ptq_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ptq_pkg::ptq_res_t m_data
);
    import ptq_pkg::*;

    logic     en;
    ptq_div_t prep_next;
    ptq_div_t div_data  [0:PRICE_W];
    logic     div_valid [0:PRICE_W];
    logic     prep_valid_reg;
    ptq_div_t prep_reg;
    logic     fx_valid;
    ptq_res_t fx_data;
    logic     m_valid_reg;
    ptq_res_t m_data_reg;
    logic     skid_valid_reg;
    ptq_res_t skid_data_reg;
    logic     take;

    // The whole pipeline advances while the output buffer has room.
    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign take    = m_valid_reg && m_ready;

    // Input stage: sign, magnitude and control bits.
    always_comb begin
        prep_next         = '0;
        prep_next.ctl.neg = s_data.price[PRICE_W-1];
        prep_next.ctl.bad = (s_data.tick == '0);
        prep_next.ctl.op  = s_data.opcode;
        prep_next.a       = s_data.price[PRICE_W-1] ? ('0 - s_data.price) : s_data.price;
        prep_next.tick    = s_data.tick;
        prep_next.rem     = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            prep_reg <= prep_next;
        end
    end

    assign div_valid[0] = prep_valid_reg;
    assign div_data[0]  = prep_reg;

    // Divider chain, most significant dividend bit first.
    for (genvar i = 0; i < PRICE_W; i++) begin : g_div
        ptq_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_valid[i]),
            .in_data   (div_data[i]),
            .in_bit    (div_data[i].a[PRICE_W-1-i]),
            .out_valid (div_valid[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // Result formation from the remainder.
    ptq_fixup u_fixup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid[PRICE_W]),
        .in_data   (div_data[PRICE_W]),
        .out_valid (fx_valid),
        .out_data  (fx_data)
    );

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (fx_valid) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (fx_valid) begin
            if (!m_valid_reg || m_ready) begin
                m_data_reg <= fx_data;
            end else begin
                skid_data_reg <= fx_data;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // A buffered result always sits behind a presented one.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry holds a result while the output is empty");

    // A full buffer with no take stays full, so nothing is overwritten.
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> skid_valid_reg && m_valid_reg)
        else $error("buffered result lost during a stall");

    // A zero tick passes the price unchanged.
    a_bad_unchanged: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.bad_tick |-> !m_data_reg.changed)
        else $error("zero tick reported a changed price");

    // The pipeline never advances while the buffer is full.
    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !s_ready)
        else $error("request taken while the output buffer is full");
`endif

endmodule

`default_nettype wire
